/* hdl/gwch_pkg.sv */
package gwch_pkg;

   // default sizing of the point store and the coordinate datapath
   localparam int MAX_POINTS_DEF  = 64;
   localparam int COORD_BITS_DEF  = 16;

   // width of a coordinate on the stream ports
   localparam int IO_COORD_BITS   = 16;

   // smallest set that can form a hull
   localparam int MIN_HULL_POINTS = 3;

   // status from the orientation unit back to the sequencer
   typedef struct packed {
      logic done;
      logic neg;
   } turn_rsp_type;

endpackage

/* hdl/gift_wrap_convex_hull.sv */
// Gift-wrap convex hull. Points stream in one request per cycle while the request side
// is ready and are kept in an on-chip store of MAX_POINTS entries; a request with tlast
// set closes the set and starts the hull. Points past capacity are dropped and reported
// on every result of that set. Fewer than three stored points give a single empty
// result. Otherwise the block finds the leftmost point (earliest on ties), then for
// each hull vertex reads every stored point once and runs an orientation test on a
// shared multiply unit; each test is paced by the single store read port and the one
// multiplier taking both cross-product terms. The request side is not ready while the
// hull is computed; results leave through an output register.
module gift_wrap_convex_hull
   import gwch_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // point_x[15:0], point_y[31:16]
   input  logic        req_tlast,  // last_point
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // hull_x[15:0], hull_y[31:16]
   output logic        rsp_tlast,  // last_vertex
   output logic [1:0]  rsp_tuser   // hull_empty[0], points_dropped[1]
);

   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int WB = (COORD_BITS > IO_COORD_BITS) ? COORD_BITS : IO_COORD_BITS;

   typedef enum logic [9:0] {
      S_LOAD     = 10'b00_0000_0001,
      S_EMPTY    = 10'b00_0000_0010,
      S_MIN_RD   = 10'b00_0000_0100,
      S_MIN_CMP  = 10'b00_0000_1000,
      S_NXT_RD   = 10'b00_0001_0000,
      S_NXT_LD   = 10'b00_0010_0000,
      S_TST_RD   = 10'b00_0100_0000,
      S_TST_GO   = 10'b00_1000_0000,
      S_TST_WAIT = 10'b01_0000_0000,
      S_EMIT     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] emit_cnt_ff, emit_cnt_in;
   logic [IW-1:0] cur_idx_ff, cur_idx_in;
   logic [IW-1:0] start_idx_ff, start_idx_in;
   logic [IW-1:0] nxt_idx_ff, nxt_idx_in;

   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] nxt_x_ff, nxt_x_in, nxt_y_ff, nxt_y_in;
   logic signed [COORD_BITS-1:0] b_x_ff, b_x_in, b_y_ff, b_y_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IO_COORD_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_empty_ff, out_empty_in;
   logic                     out_drop_ff, out_drop_in;
   logic                     out_wr;

   logic                 req_accept;
   logic                 store_wr;
   logic [WB-1:0]        wide_x, wide_y;
   logic [COORD_BITS-1:0] in_x, in_y;
   logic [IW-1:0]        rd_addr;
   logic [COORD_BITS-1:0] rd_x, rd_y;
   logic signed [COORD_BITS-1:0] rd_xs, rd_ys;
   logic signed [WB-1:0] cur_x_wide, cur_y_wide;
   logic [CW-1:0]        count_new;
   logic [CW-1:0]        cur_p1, scan_p1;
   logic [IW-1:0]        wrap_idx;
   logic                 scan_end;
   logic                 out_free;
   logic                 is_last;
   turn_rsp_type         turn_rsp;

   // incoming coordinates taken as COORD_BITS two's complement
   assign wide_x = WB'(req_tdata[15:0]);
   assign wide_y = WB'(req_tdata[31:16]);
   assign in_x   = wide_x[COORD_BITS-1:0];
   assign in_y   = wide_y[COORD_BITS-1:0];

   assign req_tready = (state_ff == S_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign store_wr   = req_accept && (count_ff < CW'(MAX_POINTS));
   assign count_new  = store_wr ? count_ff + CW'(1) : count_ff;

   // index helpers for the wrap
   assign cur_p1   = CW'(cur_idx_ff) + CW'(1);
   assign wrap_idx = (cur_p1 == count_ff) ? '0 : cur_p1[IW-1:0];
   assign scan_p1  = scan_ff + CW'(1);
   assign scan_end = (scan_p1 == count_ff);
   assign rd_addr  = (state_ff == S_NXT_RD) ? wrap_idx : scan_ff[IW-1:0];

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_last  = (nxt_idx_ff == start_idx_ff) ||
                     (emit_cnt_ff == CW'(MAX_POINTS - 1));

   assign rd_xs = rd_x;
   assign rd_ys = rd_y;

   // result coordinates back to port width
   assign cur_x_wide = WB'(cur_x_ff);
   assign cur_y_wide = WB'(cur_y_ff);

   gwch_store #(
      .DEPTH      (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (count_ff[IW-1:0]),
      .wr_x    (in_x),
      .wr_y    (in_y),
      .rd_addr (rd_addr),
      .rd_x    (rd_x),
      .rd_y    (rd_y)
   );

   gwch_turn #(
      .COORD_BITS (COORD_BITS)
   ) u_turn (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_TST_GO),
      .ax    (cur_x_ff),
      .ay    (cur_y_ff),
      .bx    (rd_xs),
      .by    (rd_ys),
      .cx    (nxt_x_ff),
      .cy    (nxt_y_ff),
      .rsp   (turn_rsp)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      scan_in      = scan_ff;
      emit_cnt_in  = emit_cnt_ff;
      cur_idx_in   = cur_idx_ff;
      start_idx_in = start_idx_ff;
      nxt_idx_in   = nxt_idx_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      nxt_x_in     = nxt_x_ff;
      nxt_y_in     = nxt_y_ff;
      b_x_in       = b_x_ff;
      b_y_in       = b_y_ff;
      out_wr       = 1'b0;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      out_empty_in = out_empty_ff;
      out_drop_in  = out_drop_ff;

      case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               count_in = count_new;
               if (!store_wr) ovf_in = 1'b1;
               if (req_tlast) begin
                  scan_in = '0;
                  if (count_new < CW'(MIN_HULL_POINTS)) begin
                     state_in = S_EMPTY;
                  end else begin
                     state_in = S_MIN_RD;
                  end
               end
            end
         end
         S_EMPTY: begin
            if (out_free) begin
               out_wr       = 1'b1;
               out_x_in     = '0;
               out_y_in     = '0;
               out_last_in  = 1'b1;
               out_empty_in = 1'b1;
               out_drop_in  = ovf_ff;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = S_LOAD;
            end
         end
         S_MIN_RD: state_in = S_MIN_CMP;
         S_MIN_CMP: begin
            if (scan_ff == '0 || rd_xs < cur_x_ff) begin
               cur_x_in     = rd_xs;
               cur_y_in     = rd_ys;
               cur_idx_in   = scan_ff[IW-1:0];
               start_idx_in = scan_ff[IW-1:0];
            end
            if (scan_end) begin
               emit_cnt_in = '0;
               state_in    = S_NXT_RD;
            end else begin
               scan_in  = scan_p1;
               state_in = S_MIN_RD;
            end
         end
         S_NXT_RD: state_in = S_NXT_LD;
         S_NXT_LD: begin
            nxt_idx_in = wrap_idx;
            nxt_x_in   = rd_xs;
            nxt_y_in   = rd_ys;
            scan_in    = '0;
            state_in   = S_TST_RD;
         end
         S_TST_RD: state_in = S_TST_GO;
         S_TST_GO: begin
            b_x_in   = rd_xs;
            b_y_in   = rd_ys;
            state_in = S_TST_WAIT;
         end
         S_TST_WAIT: begin
            if (turn_rsp.done) begin
               if (turn_rsp.neg) begin
                  nxt_idx_in = scan_ff[IW-1:0];
                  nxt_x_in   = b_x_ff;
                  nxt_y_in   = b_y_ff;
               end
               if (scan_end) begin
                  state_in = S_EMIT;
               end else begin
                  scan_in  = scan_p1;
                  state_in = S_TST_RD;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_wr       = 1'b1;
               out_x_in     = cur_x_wide[IO_COORD_BITS-1:0];
               out_y_in     = cur_y_wide[IO_COORD_BITS-1:0];
               out_last_in  = is_last;
               out_empty_in = 1'b0;
               out_drop_in  = ovf_ff;
               if (is_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  cur_idx_in  = nxt_idx_ff;
                  cur_x_in    = nxt_x_ff;
                  cur_y_in    = nxt_y_ff;
                  emit_cnt_in = emit_cnt_ff + CW'(1);
                  state_in    = S_NXT_RD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   // output register valid
   always_comb begin
      if (out_wr) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk registers and result payload
   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      emit_cnt_ff  <= emit_cnt_in;
      cur_idx_ff   <= cur_idx_in;
      start_idx_ff <= start_idx_in;
      nxt_idx_ff   <= nxt_idx_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      nxt_x_ff     <= nxt_x_in;
      nxt_y_ff     <= nxt_y_in;
      b_x_ff       <= b_x_in;
      b_y_ff       <= b_y_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
      out_drop_ff  <= out_drop_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_y_ff, out_x_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_drop_ff, out_empty_ff};

   // orientation results only arrive while the sequencer waits for them
   a_turn_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      turn_rsp.done |-> state_ff == S_TST_WAIT)
      else $error("orientation result outside the wait state");

   // an empty result is a single zero vertex that closes the hull
   a_empty_is_zero_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && rsp_tdata == '0)
      else $error("empty result not zero or not last");

   // candidate scan stays inside the loaded set
   a_scan_in_set: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TST_WAIT |-> scan_ff < count_ff)
      else $error("scan index beyond the stored points");

   // closing a set stops further requests
   a_last_closes_set: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("request taken right after the last point");

endmodule

/* hdl/gwch_store.sv */
module gwch_store
   import gwch_pkg::*;
#(
   parameter int DEPTH      = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [COORD_BITS-1:0]         wr_x,
   input  logic [COORD_BITS-1:0]         wr_y,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [COORD_BITS-1:0]         rd_x,
   output logic [COORD_BITS-1:0]         rd_y
);

   logic [2*COORD_BITS-1:0] mem_ff [DEPTH];
   logic [2*COORD_BITS-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_y, wr_x};
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_x = rd_data_ff[COORD_BITS-1:0];
   assign rd_y = rd_data_ff[2*COORD_BITS-1:COORD_BITS];

endmodule

/* hdl/gwch_turn.sv */
module gwch_turn
   import gwch_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] ax,
   input  logic signed [COORD_BITS-1:0] ay,
   input  logic signed [COORD_BITS-1:0] bx,
   input  logic signed [COORD_BITS-1:0] by,
   input  logic signed [COORD_BITS-1:0] cx,
   input  logic signed [COORD_BITS-1:0] cy,
   output turn_rsp_type                 rsp
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   typedef enum logic [3:0] {
      T_IDLE = 4'b0001,
      T_MUL1 = 4'b0010,
      T_MUL2 = 4'b0100,
      T_DONE = 4'b1000
   } phase_type;

   phase_type phase_ff, phase_in;

   logic signed [DW-1:0] d1_ff, d2_ff, d3_ff, d4_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic signed [DW-1:0] op_a, op_b;
   logic signed [PW-1:0] prod;

   // phase sequencing: latch differences, two products, then report
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         T_IDLE: begin
            if (start) phase_in = T_MUL1;
         end
         T_MUL1: phase_in = T_MUL2;
         T_MUL2: phase_in = T_DONE;
         T_DONE: phase_in = T_IDLE;
         default: phase_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= T_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // single shared multiplier, operands picked by phase
   assign op_a = (phase_ff == T_MUL1) ? d1_ff : d3_ff;
   assign op_b = (phase_ff == T_MUL1) ? d2_ff : d4_ff;
   assign prod = PW'(op_a) * PW'(op_b);

   always_ff @(posedge clock) begin
      if (start && phase_ff == T_IDLE) begin
         d1_ff <= DW'(by) - DW'(ay);
         d2_ff <= DW'(cx) - DW'(bx);
         d3_ff <= DW'(bx) - DW'(ax);
         d4_ff <= DW'(cy) - DW'(by);
      end
      if (phase_ff == T_MUL1) p1_ff <= prod;
      if (phase_ff == T_MUL2) p2_ff <= prod;
   end

   // cross product is negative exactly when the first product is smaller
   assign rsp.done = (phase_ff == T_DONE);
   assign rsp.neg  = (p1_ff < p2_ff);

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import gwch_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_POINTS = 246;
   localparam int DRAIN_CYCLES  = 200;
   localparam int MAX_WAIT      = 12;
   localparam int REPORT_LIMIT  = 10;

   typedef logic signed [IO_COORD_BITS-1:0] coord_type;

   // one hull vertex as seen on the result stream
   typedef struct packed {
      logic signed [IO_COORD_BITS-1:0] x;
      logic signed [IO_COORD_BITS-1:0] y;
      logic                            last;
      logic                            empty;
      logic                            dropped;
   } hull_vertex_type;

   typedef enum int {
      STYLE_WIDE,
      STYLE_GRID,
      STYLE_PARABOLA,
      STYLE_CORNER
   } point_style_type;

   // gift-wrap predictor and store of expected hull vertices
   class hull_scoreboard;
      coord_type       store_x [MAX_POINTS_DEF];
      coord_type       store_y [MAX_POINTS_DEF];
      int              stored;
      bit              overflow;
      hull_vertex_type expected_vertices[$];
      int              errors;
      int              vertices_checked;
      int              overflow_sets;

      // append one vertex at the tail of the expected queue
      function void add_expected(hull_vertex_type v);
         expected_vertices.insert(expected_vertices.size(), v);
      endfunction

      // store one accepted point, and on the last one walk the hull
      function void note_point(coord_type px, coord_type py, bit last_pt);
         hull_vertex_type v;
         int              n;
         int              start;
         int              cur;
         int              nxt;
         int              emitted;
         longint          turn;
         if (stored < MAX_POINTS_DEF) begin
            store_x[stored] = px;
            store_y[stored] = py;
            stored++;
         end else begin
            overflow = 1'b1;
         end
         if (!last_pt)
            return;
         n = stored;
         if (overflow)
            overflow_sets++;
         v.dropped = overflow;
         if (n < MIN_HULL_POINTS) begin
            v.x     = '0;
            v.y     = '0;
            v.last  = 1'b1;
            v.empty = 1'b1;
            add_expected(v);
         end else begin
            // leftmost point, earliest on ties
            start = 0;
            for (int i = 1; i < n; i++)
               if (store_x[i] < store_x[start])
                  start = i;
            cur     = start;
            emitted = 0;
            v.last  = 1'b0;
            v.empty = 1'b0;
            do begin
               v.x = store_x[cur];
               v.y = store_y[cur];
               add_expected(v);
               emitted++;
               // most counterclockwise candidate, colinear ones never replace
               nxt = (cur + 1) % n;
               for (int i = 0; i < n; i++) begin
                  turn = (longint'(store_y[i]) - longint'(store_y[cur]))
                         * (longint'(store_x[nxt]) - longint'(store_x[i]))
                         - (longint'(store_x[i]) - longint'(store_x[cur]))
                         * (longint'(store_y[nxt]) - longint'(store_y[i]));
                  if (turn < 0)
                     nxt = i;
               end
               cur = nxt;
            end while (cur != start && emitted < MAX_POINTS_DEF);
            expected_vertices[expected_vertices.size() - 1].last = 1'b1;
         end
         stored   = 0;
         overflow = 1'b0;
      endfunction

      // compare one accepted result with the oldest expected vertex
      function void check_vertex(hull_vertex_type got);
         hull_vertex_type want;
         if (expected_vertices.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("tb: unexpected result x=%0d y=%0d last=%0b empty=%0b dropped=%0b",
                        got.x, got.y, got.last, got.empty, got.dropped);
            return;
         end
         want = expected_vertices.pop_front();
         vertices_checked++;
         if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
             got.empty !== want.empty || got.dropped !== want.dropped) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("tb: mismatch at %0t: expected x=%0d y=%0d last=%0b empty=%0b dropped=%0b",
                        $realtime, want.x, want.y, want.last, want.empty, want.dropped);
               $display("tb:    got x=%0d y=%0d last=%0b empty=%0b dropped=%0b",
                        got.x, got.y, got.last, got.empty, got.dropped);
            end
         end
      endfunction

      function int pending();
         return expected_vertices.size();
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   hull_scoreboard board = new;

   int              cycle_count = 0;
   int              points_sent = 0;
   int              sets_sent   = 0;
   bit              req_burst   = 1'b0;
   bit              rsp_burst   = 1'b0;
   int              rsp_wait    = 0;
   hull_vertex_type seen;

   gift_wrap_convex_hull i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // timeout
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: timeout after %0d cycles, %0d results outstanding",
               cycle_count, board.pending());
      $display("tb: failure");
      $finish;
   end

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic coord_type pick_extreme();
      case ($urandom_range(0, 3))
         0: return coord_type'(-32768);
         1: return coord_type'(32767);
         2: return '0;
         default: return coord_type'($urandom);
      endcase
   endfunction

   // result side: check each accepted vertex, then stall a random while
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.x       = rsp_tdata[15:0];
         seen.y       = rsp_tdata[31:16];
         seen.last    = rsp_tlast;
         seen.empty   = rsp_tuser[0];
         seen.dropped = rsp_tuser[1];
         board.check_vertex(seen);
         if ($urandom_range(0, 19) == 0)
            rsp_burst = !rsp_burst;
         rsp_wait = draw_wait(rsp_burst);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
      end
      rsp_tready <= !reset && rsp_wait == 0;
   end

   // one point request, held until accepted
   task automatic send_point(coord_type px, coord_type py, bit last_pt);
      int gap;
      gap = draw_wait(req_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      req_tlast  <= last_pt;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_point(px, py, last_pt);
      points_sent++;
      if (last_pt)
         sets_sent++;
   endtask

   // a whole point set of one flavor, last mark on the final point
   task automatic send_set(point_style_type style, int size);
      coord_type px;
      coord_type py;
      int        k;
      bit        flip;
      flip = $urandom_range(0, 1);
      for (int i = 0; i < size; i++) begin
         case (style)
            STYLE_WIDE: begin
               px = coord_type'($urandom);
               py = coord_type'($urandom);
            end
            STYLE_GRID: begin
               px = coord_type'($urandom_range(0, 6) - 3);
               py = coord_type'($urandom_range(0, 6) - 3);
            end
            STYLE_PARABOLA: begin
               // points on a parabola are nearly all hull vertices
               k  = int'($urandom_range(0, 360)) - 180;
               px = coord_type'(k);
               py = coord_type'(flip ? 16384 - k * k : k * k - 16384);
            end
            default: begin
               px = pick_extreme();
               py = pick_extreme();
            end
         endcase
         send_point(px, py, i == size - 1);
      end
   endtask

   initial begin
      int              random_points;
      int              set_index;
      int              size;
      point_style_type style;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single point and two points: empty hull
      send_point(-32768, 32767, 1'b1);
      send_point(32767, -32768, 1'b0);
      send_point(-1, 0, 1'b1);
      // full-range square with a center point
      send_point(-32768, -32768, 1'b0);
      send_point(32767, -32768, 1'b0);
      send_point(32767, 32767, 1'b0);
      send_point(-32768, 32767, 1'b0);
      send_point(0, 0, 1'b1);
      // tie on the leftmost x: earliest one starts the walk
      send_point(-5, 3, 1'b0);
      send_point(-5, -3, 1'b0);
      send_point(4, 0, 1'b0);
      send_point(-5, 0, 1'b1);
      // all points on one line
      send_point(0, 0, 1'b0);
      send_point(1, 1, 1'b0);
      send_point(2, 2, 1'b0);
      send_point(3, 3, 1'b1);
      // identical points
      send_point(7, 7, 1'b0);
      send_point(7, 7, 1'b0);
      send_point(7, 7, 1'b1);
      // triangle with points on its edges
      send_point(0, 0, 1'b0);
      send_point(10, 0, 1'b0);
      send_point(5, 0, 1'b0);
      send_point(0, 10, 1'b0);
      send_point(5, 5, 1'b1);

      // random sets, two of them past the store capacity
      random_points = 0;
      set_index     = 0;
      while (random_points < RANDOM_POINTS) begin
         if (set_index == 0)
            size = MAX_POINTS_DEF + 1;
         else if (set_index == 9)
            size = MAX_POINTS_DEF + 3;
         else
            size = $urandom_range(1, 12);
         if (size > MAX_POINTS_DEF)
            style = STYLE_PARABOLA;
         else
            style = point_style_type'($urandom_range(0, 3));
         if ($urandom_range(0, 3) == 0)
            req_burst = !req_burst;
         send_set(style, size);
         random_points += size;
         set_index++;
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      // drain, then watch for stray results
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d points in %0d sets, %0d sets with dropped points",
               points_sent, sets_sent, board.overflow_sets);
      $display("tb: %0d hull results checked, %0d errors in %0d cycles",
               board.vertices_checked, board.errors, cycle_count);
      if (board.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
